FILE: rtl/core/mta_pkg.sv
// Package: types, constants and command codes for the matrix transform accumulator.
package mta_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int CF               = 30;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [39:0] K_Q30 = 40'sh0026DD3B6A;

    typedef enum logic [2:0] {
        CMD_IDENT  = 3'd0,
        CMD_SCALE  = 3'd1,
        CMD_TRANS  = 3'd2,
        CMD_ROTX   = 3'd3,
        CMD_ROTY   = 3'd4,
        CMD_ROTZ   = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] arg_x;
        logic signed [31:0] arg_y;
        logic signed [31:0] arg_z;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] elem_0;
        logic signed [31:0] elem_1;
        logic signed [31:0] elem_2;
        logic signed [31:0] elem_3;
        logic               angle_error;
        logic               last_row;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_EMIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture input word, prepare angle
        logic step;      // one CORDIC iteration
        logic mul;       // one multiply step (row and column from r_el)
        logic emit;      // present the row selected by row counter
    } t_ctrl;

    // Datapath to controller.
    typedef struct packed {
        logic need_rot;  // valid rotation in progress
        logic need_mul;  // matrix is updated by a multiply
        logic cordic_done;
        logic mul_done;
    } t_stat;

    function automatic logic signed [39:0] atan_q30(input int i);
        logic signed [39:0] t [ATAN_LEN] = '{
            40'sh3243F6A8, 40'sh1DAC6705, 40'sh0FADBAFC, 40'sh07F56EA6,
            40'sh03FEAB76, 40'sh01FFD55B, 40'sh00FFFAAA, 40'sh007FFF55,
            40'sh003FFFEA, 40'sh001FFFFD, 40'sh000FFFFF, 40'sh0007FFFF,
            40'sh0003FFFF, 40'sh0001FFFF, 40'sh0000FFFF, 40'sh00007FFF,
            40'sh00003FFF, 40'sh00001FFF, 40'sh00000FFF, 40'sh000007FF,
            40'sh000003FF, 40'sh000001FF, 40'sh000000FF, 40'sh0000007F};
        return t[i];
    endfunction

endpackage

FILE: rtl/core/mta_ctrl.sv
// Controller: sequences load, CORDIC, multiply and row emission.
module mta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_row,
    output mta_pkg::t_ctrl o_ctrl,
    input  mta_pkg::t_stat i_stat
);
    import mta_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_row, n_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        case (r_state)
            ST_IDLE: begin
                n_row = '0;
                if (i_valid) n_state = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (!i_stat.need_rot || i_stat.cordic_done)
                    n_state = i_stat.need_mul ? ST_MUL : ST_EMIT;
            end
            ST_MUL: begin
                if (i_stat.mul_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_row = r_row + 2'd1;
                    if (r_row == 2'd3) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_row       = r_row;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_valid;
            end
            ST_CORDIC: o_ctrl.step = i_stat.need_rot && !i_stat.cordic_done;
            ST_MUL:    o_ctrl.mul  = 1'b1;
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_ctrl.emit = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

FILE: rtl/core/mta_dp.sv
// Datapath: matrix storage, CORDIC unit and one-element-per-cycle multiplier.
module mta_dp #(
    parameter int FRAC_BITS    = mta_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = mta_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mta_pkg::t_in_word i_word,
    input  mta_pkg::t_ctrl    i_ctrl,
    input  logic [1:0]        i_row,
    output mta_pkg::t_stat    o_stat,
    output mta_pkg::t_out_word o_word
);
    import mta_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int SW = $clog2(NSTEP + 1);
    localparam int SH = CF - FRAC_BITS;
    localparam logic signed [39:0] PI30 = 40'((PI_Q60 + (64'd1 << 29)) >> 30);
    localparam logic signed [39:0] HPI30 = 40'((PI_Q60 + (64'd1 << 30)) >> 31);
    localparam logic signed [33:0] PIQ =
        34'((PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] r_m [16];
    logic [2:0]         r_cmd;
    logic signed [31:0] r_ax, r_ay, r_az;
    logic               r_err, r_rot, r_mul;
    logic signed [39:0] r_x, r_y, r_z;
    logic               r_neg;
    logic [SW-1:0]      r_it;
    logic [4:0]         r_el;     // {row, col} plus done bit
    logic signed [31:0] r_new [16];

    // angle prep
    logic signed [39:0] w_z0;
    logic               w_bad, w_rotcmd;
    assign w_z0 = 40'(i_word.arg_x) <<< SH;
    assign w_rotcmd = i_word.command == CMD_ROTX || i_word.command == CMD_ROTY ||
                      i_word.command == CMD_ROTZ;
    assign w_bad = 34'(i_word.arg_x) > PIQ || 34'(i_word.arg_x) < -PIQ;

    // CORDIC step
    logic [4:0] w_i;
    logic signed [39:0] w_xs, w_ys;
    assign w_i  = 5'(r_it);
    assign w_xs = r_x >>> w_i;
    assign w_ys = r_y >>> w_i;

    // cos/sin rounded
    logic signed [39:0] w_cr, w_sr;
    logic signed [31:0] w_c, w_s;
    assign w_cr = (r_x + (40'sd1 <<< (SH - 1))) >>> SH;
    assign w_sr = (r_y + (40'sd1 <<< (SH - 1))) >>> SH;
    assign w_c  = r_neg ? -32'(w_cr) : 32'(w_cr);
    assign w_s  = r_neg ? -32'(w_sr) : 32'(w_sr);

    // operand column entry b[k][col]
    function automatic logic signed [31:0] bval(input logic [1:0] k, input logic [1:0] c,
        input logic [2:0] cmd, input logic signed [31:0] ax, ay, az, cs, sn);
        logic signed [31:0] v;
        v = (k == c) ? ONE : 32'sd0;
        case (cmd)
            CMD_SCALE: if (k == c) begin
                if (k == 2'd0) v = ax; else if (k == 2'd1) v = ay;
                else if (k == 2'd2) v = az;
            end
            CMD_TRANS: if (k == 2'd3) begin
                if (c == 2'd0) v = ax; else if (c == 2'd1) v = ay;
                else if (c == 2'd2) v = az;
            end
            CMD_ROTX: begin
                if ((k == 2'd1 && c == 2'd1) || (k == 2'd2 && c == 2'd2)) v = cs;
                if (k == 2'd1 && c == 2'd2) v = -sn;
                if (k == 2'd2 && c == 2'd1) v = sn;
            end
            CMD_ROTY: begin
                if ((k == 2'd0 && c == 2'd0) || (k == 2'd2 && c == 2'd2)) v = cs;
                if (k == 2'd0 && c == 2'd2) v = -sn;
                if (k == 2'd2 && c == 2'd0) v = sn;
            end
            CMD_ROTZ: begin
                if ((k == 2'd0 && c == 2'd0) || (k == 2'd1 && c == 2'd1)) v = cs;
                if (k == 2'd0 && c == 2'd1) v = -sn;
                if (k == 2'd1 && c == 2'd0) v = sn;
            end
            default: ;
        endcase
        return v;
    endfunction

    // one element per cycle: four 32x32 products, summed, saturated
    logic [1:0] w_r, w_c2;
    logic signed [63:0] w_p [4];
    logic signed [63:0] w_sum;
    logic signed [31:0] w_sat;
    assign w_r  = r_el[3:2];
    assign w_c2 = r_el[1:0];
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < 4; k++) begin
            w_p[k] = 64'(r_m[{w_r, 2'(k)}]) *
                     64'(bval(2'(k), w_c2, r_cmd, r_ax, r_ay, r_az, w_c, w_s));
            w_sum = w_sum + (w_p[k] >>> FRAC_BITS);
        end
        if (w_sum > 64'sh000000007FFFFFFF) w_sat = 32'sh7FFFFFFF;
        else if (w_sum < -64'sh0000000080000000) w_sat = 32'sh80000000;
        else w_sat = 32'(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_m[k] <= (k % 5 == 0) ? ONE : 32'sd0;
            r_err <= 1'b0;
            r_rot <= 1'b0;
            r_mul <= 1'b0;
            r_it  <= '0;
            r_el  <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_cmd <= i_word.command;
                r_ax  <= i_word.arg_x;
                r_ay  <= i_word.arg_y;
                r_az  <= i_word.arg_z;
                r_err <= w_rotcmd && w_bad;
                r_rot <= w_rotcmd && !w_bad;
                r_mul <= (i_word.command == CMD_SCALE) || (i_word.command == CMD_TRANS) ||
                         (w_rotcmd && !w_bad);
                r_it  <= '0;
                r_el  <= '0;
                r_x   <= K_Q30;
                r_y   <= '0;
                r_neg <= 1'b0;
                if (w_rotcmd && w_z0 > HPI30) begin
                    r_z <= w_z0 - PI30; r_neg <= 1'b1;
                end else if (w_rotcmd && w_z0 < -HPI30) begin
                    r_z <= w_z0 + PI30; r_neg <= 1'b1;
                end else begin
                    r_z <= w_z0;
                end
                if (i_word.command == CMD_IDENT)
                    for (int k = 0; k < 16; k++) r_m[k] <= (k % 5 == 0) ? ONE : 32'sd0;
            end
            if (i_ctrl.step) begin
                r_it <= r_it + SW'(1);
                if (r_z >= 0) begin
                    r_x <= r_x - w_ys; r_y <= r_y + w_xs; r_z <= r_z - atan_q30(int'(r_it));
                end else begin
                    r_x <= r_x + w_ys; r_y <= r_y - w_xs; r_z <= r_z + atan_q30(int'(r_it));
                end
            end
            if (i_ctrl.mul) begin
                r_new[r_el[3:0]] <= w_sat;
                r_el <= r_el + 5'd1;
                if (r_el == 5'd16)
                    for (int k = 0; k < 16; k++) r_m[k] <= r_new[k];
            end
        end
    end

    assign o_stat.need_rot    = r_rot;
    assign o_stat.need_mul    = r_mul;
    assign o_stat.cordic_done = r_it == SW'(NSTEP);
    assign o_stat.mul_done    = r_el == 5'd16;

    assign o_word.row_index   = i_row;
    assign o_word.elem_0      = r_m[{i_row, 2'd0}];
    assign o_word.elem_1      = r_m[{i_row, 2'd1}];
    assign o_word.elem_2      = r_m[{i_row, 2'd2}];
    assign o_word.elem_3      = r_m[{i_row, 2'd3}];
    assign o_word.angle_error = r_err;
    assign o_word.last_row    = i_ctrl.emit && i_row == 2'd3;
endmodule

FILE: rtl/core/matrix_transform_accumulator.sv
// Top level of the 4x4 matrix transform accumulator.
// Usage:
//   Input channel (i_valid/o_ready, i_in) carries one command word: identity,
//   scale, translate or rotate about x, y or z, with Q16.16 arguments.
//   Output channel (o_valid/i_ready, o_out) returns four row words of the
//   updated matrix, row 0 first; last_row marks row 3.
//   A rotation angle beyond plus or minus pi sets angle_error on all four
//   rows and leaves the matrix as it was.
// Sequence:
//   One command at a time: accept, then the CORDIC iterations for a rotation
//   (passing straight through otherwise), then the multiply (one matrix
//   element a cycle through four 32x32 multipliers, plus commit), then four
//   row words, one a cycle when the receiver is ready. Identity, rejected
//   angles and unused codes skip the multiply. CORDIC and multiply loops set the rate.
// Reset: synchronous, active low; matrix returns to identity.
// A stalled receiver holds the current row word until it is taken.
module matrix_transform_accumulator #(
    parameter int FRAC_BITS    = mta_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = mta_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mta_pkg::t_in_word  i_in,
    output logic               o_valid,
    input  logic               i_ready,
    output mta_pkg::t_out_word o_out
);
    import mta_pkg::*;

    t_ctrl      w_ctrl;
    t_stat      w_stat;
    logic [1:0] w_row;

    mta_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_in_ready(o_ready),
        .i_out_ready(i_ready), .o_out_valid(o_valid), .o_row(w_row),
        .o_ctrl(w_ctrl), .i_stat(w_stat)
    );

    mta_dp #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(i_in), .i_ctrl(w_ctrl),
        .i_row(w_row), .o_stat(w_stat), .o_word(o_out)
    );
endmodule

FILE: rtl/core/mta_checker.sv
// Port-level checker for the matrix transform accumulator, with its bind.
module mta_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input mta_pkg::t_out_word o_out
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken during output");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.last_row == (o_out.row_index == 2'd3)))
        else $error("last_row mismatch");
    a_row_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_out.row_index != 2'd3) |=>
        (o_valid && o_out.row_index == $past(o_out.row_index) + 2'd1))
        else $error("row sequence broken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out)))
        else $error("output changed while stalled");
endmodule

bind matrix_transform_accumulator mta_checker u_mta_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out)
);

FILE: bench/matrix_transform_accumulator_checker.sv
// Checker: predicts the matrix rows for each command word and compares the output words.
`timescale 1ns / 100ps
module matrix_transform_accumulator_checker
    import mta_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_ready_in,
    input  t_in_word  i_in,
    input  logic      i_valid_out,
    input  logic      i_ready,
    input  t_out_word i_out,
    output int        o_errors,
    output int        o_pending
);
    longint    mat [16];
    t_out_word row_q [$];

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_entry(int i);
        logic signed [39:0] t;
        t = atan_q30(i);
        return longint'(t);
    endfunction

    task automatic sin_cos(input longint ang, output longint co, output longint si);
        longint pi30, hpi30, z, x, y, nx, half;
        logic [63:0] p;
        bit neg;
        p = PI_Q60 + (64'd1 << 29);
        pi30 = longint'(p >> 30);
        p = PI_Q60 + (64'd1 << 30);
        hpi30 = longint'(p >> 31);
        z = ang * (64'sd1 <<< (CF - FRAC_BITS));
        x = longint'(K_Q30);
        y = 0;
        half = 64'sd1 <<< (CF - FRAC_BITS - 1);
        neg = 0;
        if (z > hpi30) begin
            z -= pi30; neg = 1;
        end else if (z < -hpi30) begin
            z += pi30; neg = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i); y = y + fshr(x, i); z -= atan_entry(i);
            end else begin
                nx = x + fshr(y, i); y = y - fshr(x, i); z += atan_entry(i);
            end
            x = nx;
        end
        x = fshr(x + half, CF - FRAC_BITS);
        y = fshr(y + half, CF - FRAC_BITS);
        if (neg) begin
            x = -x; y = -y;
        end
        co = x;
        si = y;
    endtask

    function automatic void load_ident(ref longint m [16]);
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? (64'sd1 <<< FRAC_BITS) : 0;
    endfunction

    task automatic apply_word(input t_in_word w);
        longint b [16];
        longint nm [16];
        longint ax, ay, az, co, si, pq, acc;
        logic [63:0] p;
        bit err, mul;
        t_out_word r;
        ax = longint'(w.arg_x); ay = longint'(w.arg_y); az = longint'(w.arg_z);
        p = PI_Q60 + (64'd1 << (59 - FRAC_BITS));
        pq = longint'(p >> (60 - FRAC_BITS));
        err = 0;
        mul = 0;
        load_ident(b);
        case (w.command)
            CMD_IDENT: load_ident(mat);
            CMD_SCALE: begin
                b[0] = ax; b[5] = ay; b[10] = az; mul = 1;
            end
            CMD_TRANS: begin
                b[12] = ax; b[13] = ay; b[14] = az; mul = 1;
            end
            CMD_ROTX, CMD_ROTY, CMD_ROTZ: begin
                if (ax > pq || ax < -pq) begin
                    err = 1;
                end else begin
                    sin_cos(ax, co, si);
                    mul = 1;
                    if (w.command == CMD_ROTX) begin
                        b[5] = co; b[6] = -si; b[9] = si; b[10] = co;
                    end else if (w.command == CMD_ROTY) begin
                        b[0] = co; b[2] = -si; b[8] = si; b[10] = co;
                    end else begin
                        b[0] = co; b[1] = -si; b[4] = si; b[5] = co;
                    end
                end
            end
            default: ;
        endcase
        if (mul) begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++) begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += fshr(mat[i*4+k] * b[k*4+j], FRAC_BITS);
                    nm[i*4+j] = sat32(acc);
                end
            mat = nm;
        end
        for (int i = 0; i < 4; i++) begin
            r.row_index   = 2'(i);
            r.elem_0      = 32'(mat[i*4]);
            r.elem_1      = 32'(mat[i*4+1]);
            r.elem_2      = 32'(mat[i*4+2]);
            r.elem_3      = 32'(mat[i*4+3]);
            r.angle_error = err;
            r.last_row    = (i == 3);
            row_q.push_back(r);
        end
    endtask

    initial begin
        o_errors = 0;
        load_ident(mat);
    end

    assign o_pending = row_q.size();

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            load_ident(mat);
            row_q.delete();
        end else begin
            if (i_valid_out && i_ready) begin
                if (row_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_out);
                    o_errors++;
                end else begin
                    e = row_q.pop_front();
                    if (e !== i_out) begin
                        $display("%0t: row mismatch expected %h actual %h", $time, e, i_out);
                        o_errors++;
                    end
                end
            end
            if (i_valid && i_ready_in) apply_word(i_in);
        end
    end
endmodule

FILE: bench/matrix_transform_accumulator_tb.sv
// Testbench top: drives command words and row backpressure, reports the verdict.
`timescale 1ns / 100ps
module matrix_transform_accumulator_tb;
    import mta_pkg::*;

    localparam int LIMIT = 20000;
    localparam int PI_Q  = 32'h0003243F;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    logic      o_ready;
    t_in_word  i_in = '0;
    logic      o_valid;
    logic      i_ready = 0;
    t_out_word o_out;
    int        errors, pending;
    int        idle_cycles = 0;
    bit        calm;

    always #4 i_clk = ~i_clk;

    matrix_transform_accumulator DUT (.*);

    matrix_transform_accumulator_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_in,
        .i_valid_out(o_valid), .i_ready, .i_out(o_out),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 19);
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h00010000 + $urandom_range(16'h8000) - 32'h4000;
            2: return -(32'h00010000 + $urandom_range(16'h8000));
            3: return $urandom_range(32'h40000) - 32'h20000;
            default: return $urandom_range(32'h30000) - 32'h18000;
        endcase
    endfunction

    task automatic send(input logic [2:0] c, input logic [31:0] x, y, z);
        while (!calm && $urandom_range(99) < 19) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_in <= '{command: c, arg_x: x, arg_y: y, arg_z: z};
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        logic [2:0] c;
        logic [31:0] a;
        calm = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send(CMD_SCALE, 32'h7FFFFFFF, 32'h80000000, 32'h00020000);
        send(CMD_SCALE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send(CMD_IDENT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(CMD_TRANS, 32'h80000000, 32'h7FFFFFFF, 32'h0);
        send(CMD_IDENT, 0, 0, 0);
        send(CMD_ROTX, PI_Q, 0, 0);
        send(CMD_ROTY, -PI_Q, 0, 0);
        send(CMD_ROTZ, PI_Q + 1, 0, 0);
        send(CMD_ROTX, -PI_Q - 1, 0, 0);
        send(CMD_ROTZ, 32'h80000000, 0, 0);
        send(CMD_ROTY, 32'h7FFFFFFF, 0, 0);
        send(CMD_ROTZ, 32'h0001921F, 0, 0);
        send(CMD_ROTZ, 32'h0001921F + 1, 0, 0);
        send(CMD_ROTY, -32'h0001921F - 1, 0, 0);
        send(CMD_ROTX, 0, 0, 0);
        send(3'd6, 32'h12345678, 0, 0);
        send(3'd7, 0, 0, 0);
        for (int n = 0; n < 320; n++) begin
            calm = (n >= 100 && n < 150);
            if (n % 20 == 0) c = CMD_IDENT;
            else c = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 5));
            a = rand_arg();
            if (c >= CMD_ROTX && c <= CMD_ROTZ && $urandom_range(9) != 0)
                a = $urandom_range(2 * PI_Q) - PI_Q;
            send(c, a, rand_arg(), rand_arg());
        end
        i_valid <= 0;
        calm = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
